>>> src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Holds only macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/wfsa_pkg.sv
// Package for the worst-fit segment allocator: sizes, entry and status types,
// and the scan result record passed between the scan unit and the top level.
package wfsa_pkg;

	localparam int MEM_SIZE     = 4096;
	localparam int MAX_SEGMENTS = 64;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int ADDR_W       = 12;
	localparam int LEN_W        = 13;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_FIT       = 2'd1,
		ST_TABLE_FULL   = 2'd2,
		ST_FREE_IGNORED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_DECIDE,
		S_WR2,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  length;
		logic              used;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

	localparam seg_t SEG_RESET0 = '{start: '0, length: LEN_W'(MEM_SIZE), used: 1'b0};

	typedef struct packed {
		logic              func;
		logic [LEN_W-1:0]  size;
		logic [ADDR_W-1:0] addr;
	} req_t;

	typedef struct packed {
		logic              pick_found;
		logic [IDX_W-1:0]  pick_idx;
		logic [ADDR_W-1:0] pick_start;
		logic [LEN_W-1:0]  pick_len;
		logic              spare_found;
		logic [IDX_W-1:0]  spare_idx;
		logic              node_found;
		logic [IDX_W-1:0]  node_idx;
		logic              node_used;
		logic [LEN_W-1:0]  node_len;
		logic              below_found;
		logic [IDX_W-1:0]  below_idx;
		logic [ADDR_W-1:0] below_start;
		logic [LEN_W-1:0]  below_len;
		logic              above_found;
		logic [IDX_W-1:0]  above_idx;
		logic [ADDR_W-1:0] above_start;
		logic              above_used;
		logic [LEN_W-1:0]  above_len;
	} scan_res_t;

endpackage

>>> src/wfsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module wfsa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 26
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/wfsa_scan.sv
// Scan unit: folds one segment entry per cycle, while vld is high, into the worst-fit, spare-slot
// and free-neighbour records. Depends on wfsa_pkg.
module wfsa_scan import wfsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             vld,
	input  logic [IDX_W-1:0] idx,
	input  logic             seg_valid,
	input  seg_t             seg,
	input  req_t             req,
	output scan_res_t        res
);

	scan_res_t res_q;
	scan_res_t res_d;
	logic [LEN_W-1:0] seg_end;
	logic better;

	assign seg_end = {1'b0, seg.start} + seg.length;
	assign better  = !res_q.pick_found || (seg.length > res_q.pick_len) ||
		((seg.length == res_q.pick_len) && (seg.start > res_q.pick_start));

	always_comb begin
		res_d = res_q;
		if (vld) begin
			if (!seg_valid) begin
				if (!res_q.spare_found) begin
					res_d.spare_found = 1'b1;
					res_d.spare_idx   = idx;
				end
			end else if (req.func == FN_ALLOC) begin
				if (!seg.used && (seg.length >= req.size) && better) begin
					res_d.pick_found = 1'b1;
					res_d.pick_idx   = idx;
					res_d.pick_start = seg.start;
					res_d.pick_len   = seg.length;
				end
			end else begin
				if ((seg.start == req.addr) && !res_q.node_found) begin
					res_d.node_found = 1'b1;
					res_d.node_idx   = idx;
					res_d.node_used  = seg.used;
					res_d.node_len   = seg.length;
				end
				if (!seg.used && (seg_end == {1'b0, req.addr}) && !res_q.below_found) begin
					res_d.below_found = 1'b1;
					res_d.below_idx   = idx;
					res_d.below_start = seg.start;
					res_d.below_len   = seg.length;
				end
				if ((seg.start > req.addr) &&
					(!res_q.above_found || (seg.start < res_q.above_start))) begin
					res_d.above_found = 1'b1;
					res_d.above_idx   = idx;
					res_d.above_start = seg.start;
					res_d.above_used  = seg.used;
					res_d.above_len   = seg.length;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clear) begin
			res_q <= '0;
		end else begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

>>> src/worst_fit_segment_allocator_core.sv
// Top level of the worst-fit segment allocator: request control, segment
// memory, valid bits and response registers. Depends on wfsa_pkg, wfsa_ram,
// wfsa_scan and assert_macros.svh.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------
//  request   | start / busy       | func, req_size, free_addr
//  response  | done (one cycle)   | alloc_addr, status
//
// Every request except an allocate of size zero sweeps all MAX_SEGMENTS
// entries of the segment RAM at one read a cycle, then passes through the
// S_LAST and S_DECIDE states, an extra write state (S_WR2) for a split, and
// the response state (S_RESP). A zero-size allocate goes straight to S_RESP.
// Reset leaves one free segment covering the region; no clearing pass runs.
// busy stays high from acceptance until the cycle after done.
`include "assert_macros.svh"

module worst_fit_segment_allocator_core import wfsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [LEN_W-1:0]  req_size,
	input  logic [ADDR_W-1:0] free_addr,
	output logic              done,
	output logic [ADDR_W-1:0] alloc_addr,
	output logic [1:0]        status
);

	state_t state_q, state_d;
	req_t req_q;
	logic [IDX_W-1:0] cnt_q;
	logic [MAX_SEGMENTS-1:0] valid_q;
	logic e0_fresh_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic vbit_s1;
	status_t status_q;
	logic [ADDR_W-1:0] alloc_addr_q;

	logic accept;
	logic rd_en;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	seg_t wr_data;
	logic [SEG_W-1:0] ram_rdata;
	seg_t seg_rd;
	logic v_set_en;
	logic clr_below;
	logic clr_above;
	logic resp_load;
	status_t resp_status;
	logic [ADDR_W-1:0] resp_addr;
	logic split_ok;
	logic above_merge;
	logic [LEN_W-1:0] split_sum;
	logic [LEN_W-1:0] merged_len;
	scan_res_t res;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_RESP);
	assign alloc_addr = alloc_addr_q;
	assign status     = status_q;

	wfsa_ram #(
		.DEPTH(MAX_SEGMENTS),
		.WIDTH(SEG_W)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	assign seg_rd = ((rd_idx_s1 == '0) && e0_fresh_q) ? SEG_RESET0 : seg_t'(ram_rdata);

	wfsa_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (accept),
		.vld      (rd_vld_s1),
		.idx      (rd_idx_s1),
		.seg_valid(vbit_s1),
		.seg      (seg_rd),
		.req      (req_q),
		.res      (res)
	);

	assign split_ok    = (req_q.func == FN_ALLOC) && res.pick_found &&
		(res.pick_len > req_q.size) && res.spare_found;
	assign above_merge = res.above_found && !res.above_used;
	assign split_sum   = {1'b0, res.pick_start} + req_q.size;
	assign merged_len  = res.node_len + (res.below_found ? res.below_len : '0) +
		(above_merge ? res.above_len : '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = ((func == FN_ALLOC) && (req_size == '0)) ? S_RESP : S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q == IDX_W'(MAX_SEGMENTS - 1)) begin
					state_d = S_LAST;
				end
			end
			S_LAST:   state_d = S_DECIDE;
			S_DECIDE: state_d = split_ok ? S_WR2 : S_RESP;
			S_WR2:    state_d = S_RESP;
			S_RESP:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = res.pick_idx;
		wr_data     = '{start: res.pick_start, length: res.pick_len, used: 1'b1};
		v_set_en    = 1'b0;
		clr_below   = 1'b0;
		clr_above   = 1'b0;
		resp_load   = 1'b0;
		resp_status = ST_OK;
		resp_addr   = '0;
		case (state_q)
			S_IDLE: begin
				resp_load   = accept;
				resp_status = ST_NO_FIT;
			end
			S_SCAN: begin
				rd_en = 1'b1;
			end
			S_DECIDE: begin
				resp_load = 1'b1;
				if (req_q.func == FN_ALLOC) begin
					if (!res.pick_found) begin
						resp_status = ST_NO_FIT;
					end else if (res.pick_len > req_q.size) begin
						if (!res.spare_found) begin
							resp_status = ST_TABLE_FULL;
						end else begin
							wr_en     = 1'b1;
							wr_addr   = res.spare_idx;
							wr_data   = '{start: split_sum[ADDR_W-1:0],
								length: res.pick_len - req_q.size, used: 1'b0};
							v_set_en  = 1'b1;
							resp_addr = res.pick_start;
						end
					end else begin
						wr_en     = 1'b1;
						resp_addr = res.pick_start;
					end
				end else begin
					if (!res.node_found || !res.node_used) begin
						resp_status = ST_FREE_IGNORED;
					end else begin
						wr_en     = 1'b1;
						wr_addr   = res.node_idx;
						wr_data   = '{start: res.below_found ? res.below_start : req_q.addr,
							length: merged_len, used: 1'b0};
						clr_below = res.below_found;
						clr_above = above_merge;
					end
				end
			end
			S_WR2: begin
				wr_en   = 1'b1;
				wr_data = '{start: res.pick_start, length: req_q.size, used: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			valid_q      <= MAX_SEGMENTS'(1);
			e0_fresh_q   <= 1'b1;
			rd_vld_s1    <= 1'b0;
			status_q     <= ST_OK;
			alloc_addr_q <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (v_set_en) begin
				valid_q[res.spare_idx] <= 1'b1;
			end
			if (clr_below) begin
				valid_q[res.below_idx] <= 1'b0;
			end
			if (clr_above) begin
				valid_q[res.above_idx] <= 1'b0;
			end
			if (wr_en && (wr_addr == '0)) begin
				e0_fresh_q <= 1'b0;
			end
			if (resp_load) begin
				status_q     <= resp_status;
				alloc_addr_q <= resp_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{func: func, size: req_size, addr: free_addr};
		end
		rd_idx_s1 <= cnt_q;
		vbit_s1   <= valid_q[cnt_q];
	end

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy, "busy not raised after a request")
	`ASSERT_SAME(a_table_not_empty, clk, arst_n, 1'b1, $countones(valid_q) != 0, "no valid segment")
	`ASSERT_SAME(a_addr_zero_unless_ok, clk, arst_n, done,
		(status == ST_OK) || (alloc_addr == '0), "address set on a failed request")
	`ASSERT_SAME(a_no_write_during_scan, clk, arst_n, wr_en, !rd_en && !rd_vld_s1,
		"segment write overlaps the scan")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for worst_fit_segment_allocator_core: directed, table-full and
// random request streams are checked against a segment-table predictor held in the bench.
// Depends on wfsa_pkg and the allocator RTL only.
module testbench import wfsa_pkg::*; ();

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_GAP = 80;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} alloc_resp_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              func;
	logic [LEN_W-1:0]  req_size;
	logic [ADDR_W-1:0] free_addr;
	logic              done;
	logic [ADDR_W-1:0] alloc_addr;
	logic [1:0]        status;

	int unsigned tbl_start [MAX_SEGMENTS];
	int unsigned tbl_len   [MAX_SEGMENTS];
	bit          tbl_used  [MAX_SEGMENTS];
	bit          tbl_valid [MAX_SEGMENTS];

	alloc_resp_t expected_q [$];
	int          idle_pct;
	int          cycle_count;
	int          mismatch_count;
	int          n_sent, n_granted, n_released, n_no_fit, n_table_full, n_ignored;

	worst_fit_segment_allocator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.req_size   (req_size),
		.free_addr  (free_addr),
		.done       (done),
		.alloc_addr (alloc_addr),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void table_reset();
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			tbl_start[i] = 0;
			tbl_len[i]   = 0;
			tbl_used[i]  = 1'b0;
			tbl_valid[i] = 1'b0;
		end
		tbl_len[0]   = MEM_SIZE;
		tbl_valid[0] = 1'b1;
	endfunction

	function automatic status_t predict_alloc(input int unsigned size,
						  output logic [ADDR_W-1:0] addr);
		int pick;
		int spare;
		pick  = -1;
		spare = -1;
		addr  = '0;
		if (size == 0)
			return ST_NO_FIT;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (!tbl_valid[i]) begin
				if (spare < 0)
					spare = i;
			end else if (!tbl_used[i] && tbl_len[i] >= size) begin
				if (pick < 0 || tbl_len[i] > tbl_len[pick] ||
				    (tbl_len[i] == tbl_len[pick] && tbl_start[i] > tbl_start[pick]))
					pick = i;
			end
		end
		if (pick < 0)
			return ST_NO_FIT;
		if (tbl_len[pick] > size) begin
			if (spare < 0)
				return ST_TABLE_FULL;
			tbl_valid[spare] = 1'b1;
			tbl_used[spare]  = 1'b0;
			tbl_start[spare] = tbl_start[pick] + size;
			tbl_len[spare]   = tbl_len[pick] - size;
			tbl_len[pick]    = size;
		end
		tbl_used[pick] = 1'b1;
		addr = ADDR_W'(tbl_start[pick]);
		return ST_OK;
	endfunction

	function automatic status_t predict_free(input int unsigned addr);
		int node;
		int unsigned seg_lo;
		int unsigned seg_hi;
		node = -1;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (node < 0 && tbl_valid[i] && tbl_start[i] == addr)
				node = i;
		end
		if (node < 0 || !tbl_used[node])
			return ST_FREE_IGNORED;
		tbl_used[node] = 1'b0;
		seg_lo = tbl_start[node];
		seg_hi = seg_lo + tbl_len[node];
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (i != node && tbl_valid[i] && !tbl_used[i] &&
			    tbl_start[i] + tbl_len[i] == seg_lo) begin
				tbl_start[node] = tbl_start[i];
				tbl_len[node]  += tbl_len[i];
				tbl_valid[i]    = 1'b0;
				tbl_len[i]      = 0;
				break;
			end
		end
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (i != node && tbl_valid[i] && !tbl_used[i] && tbl_start[i] == seg_hi) begin
				tbl_len[node] += tbl_len[i];
				tbl_valid[i]   = 1'b0;
				tbl_len[i]     = 0;
				break;
			end
		end
		return ST_OK;
	endfunction

	function automatic alloc_resp_t compute_response(input req_t r);
		alloc_resp_t e;
		logic [ADDR_W-1:0] a;
		a = '0;
		if (r.func == FN_ALLOC)
			e.status = predict_alloc(r.size, a);
		else
			e.status = predict_free(r.addr);
		e.addr = a;
		return e;
	endfunction

	function automatic int seg_count(input bit only_used);
		int n;
		n = 0;
		for (int i = 0; i < MAX_SEGMENTS; i++)
			if (tbl_valid[i] && (!only_used || tbl_used[i]))
				n++;
		return n;
	endfunction

	function automatic int unsigned largest_free_len();
		int unsigned best;
		best = 0;
		for (int i = 0; i < MAX_SEGMENTS; i++)
			if (tbl_valid[i] && !tbl_used[i] && tbl_len[i] > best)
				best = tbl_len[i];
		return best;
	endfunction

	// Picks the start of a random segment that is used or free as asked, or a
	// random offset when there is none.
	function automatic int unsigned pick_start(input bit want_used);
		int n;
		int k;
		n = 0;
		for (int i = 0; i < MAX_SEGMENTS; i++)
			if (tbl_valid[i] && tbl_used[i] == want_used)
				n++;
		if (n == 0)
			return $urandom_range(4095);
		k = $urandom_range(n - 1);
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (tbl_valid[i] && tbl_used[i] == want_used) begin
				if (k == 0)
					return tbl_start[i];
				k--;
			end
		end
		return 0;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic send_request(input logic fn, input int unsigned sz, input int unsigned fa);
		req_t r;
		alloc_resp_t e;
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
		r.func = fn;
		r.size = LEN_W'(sz);
		r.addr = ADDR_W'(fa);
		start     <= 1'b1;
		func      <= r.func;
		req_size  <= r.size;
		free_addr <= r.addr;
		do @(posedge clk); while (busy);
		e = compute_response(r);
		expected_q.push_back(e);
		n_sent++;
		case (e.status)
			ST_OK:           if (fn == FN_ALLOC) n_granted++; else n_released++;
			ST_NO_FIT:       n_no_fit++;
			ST_TABLE_FULL:   n_table_full++;
			ST_FREE_IGNORED: n_ignored++;
			default:         ;
		endcase
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic alloc_req(input int unsigned sz);
		send_request(FN_ALLOC, sz, $urandom_range(4095));
	endtask

	task automatic free_req(input int unsigned addr);
		send_request(FN_FREE, $urandom_range(4096), addr);
	endtask

	task automatic wait_all_done();
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic free_everything();
		while (seg_count(1'b1) != 0)
			free_req(pick_start(1'b1));
	endtask

	task automatic test_directed();
		alloc_req(0);
		free_req(0);
		alloc_req(4096);
		alloc_req(1);
		free_req(4095);
		free_req(0);
		free_req(0);
		alloc_req(1024);
		alloc_req(1024);
		alloc_req(1024);
		free_req(1024);
		// Two free segments of equal length: the higher one must be taken.
		alloc_req(512);
		alloc_req(4096);
		free_req(2048);
		free_req(3072);
		free_req(0);
		alloc_req(4096);
		free_req(0);
		alloc_req(4095);
		alloc_req(1);
		free_req(4095);
		free_req(0);
	endtask

	task automatic test_table_full();
		while (seg_count(1'b0) < MAX_SEGMENTS)
			alloc_req($urandom_range(1, 8));
		alloc_req(1);
		alloc_req(4096);
		alloc_req(largest_free_len());
		alloc_req(1);
		free_everything();
	endtask

	task automatic test_random(input int count, input int pct);
		int counted;
		int roll;
		idle_pct = pct;
		counted  = 0;
		while (counted < count) begin
			roll = $urandom_range(99);
			if (roll < 72) begin
				if (seg_count(1'b1) == 0 || $urandom_range(99) < 55) begin
					roll = $urandom_range(99);
					if (roll < 60)
						alloc_req($urandom_range(1, 64));
					else if (roll < 90)
						alloc_req($urandom_range(1, 512));
					else if (roll < 98)
						alloc_req($urandom_range(1, 4096));
					else
						alloc_req(4096);
				end else begin
					free_req(pick_start(1'b1));
				end
			end else begin
				case ($urandom_range(4))
					0: alloc_req(0);
					1: alloc_req($urandom_range(0, 4096));
					2: free_req($urandom_range(4095));
					3: free_req(pick_start(1'b0));
					default: free_req((pick_start(1'b1) + 1) % MEM_SIZE);
				endcase
			end
			counted++;
		end
	endtask

	always @(posedge clk) begin : check_results
		alloc_resp_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result addr=%0d status=%0d",
					alloc_addr, status));
			end else begin
				e = expected_q.pop_front();
				if (alloc_addr !== e.addr)
					note_mismatch($sformatf("alloc_addr expected %0d, got %0d",
						e.addr, alloc_addr));
				if (status !== e.status)
					note_mismatch($sformatf("status expected %0d, got %0d",
						e.status, status));
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.",
			cycle_count, expected_q.size());
		$display("** worst_fit_segment_allocator_core: FAILED **");
		$finish;
	end

	initial begin : main
		arst_n    = 1'b0;
		start     = 1'b0;
		func      = FN_ALLOC;
		req_size  = '0;
		free_addr = '0;
		idle_pct  = 0;
		mismatch_count = 0;
		n_sent = 0;
		n_granted = 0;
		n_released = 0;
		n_no_fit = 0;
		n_table_full = 0;
		n_ignored = 0;
		table_reset();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_table_full();
		test_random(350, 8);
		// The sender holds off here until every outstanding request has answered.
		wait_all_done();
		test_random(350, 48);
		test_random(350, 0);

		wait_all_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_q.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_q.size()));
		$display("Sent %0d requests: %0d allocations granted, %0d frees done, %0d no-fit,",
			n_sent, n_granted, n_released, n_no_fit);
		$display("%0d table-full and %0d ignored frees; %0d mismatches in %0d cycles.",
			n_table_full, n_ignored, mismatch_count, cycle_count);
		if (mismatch_count == 0)
			$display("** worst_fit_segment_allocator_core: PASSED **");
		else
			$display("** worst_fit_segment_allocator_core: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/wfsa_pkg.sv
src/wfsa_ram.sv
src/wfsa_scan.sv
src/worst_fit_segment_allocator_core.sv
tb/testbench.sv
